/* hw/rtl/dvdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvdc_pkg
// Shared types, codes and calendar tables for the date check / day count block.
// ----------------------------------------------------------------------------
package dvdc_pkg;

  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 16;
  localparam int unsigned ErrW   = 2;

  localparam logic [YearW-1:0] EpochYear = 12'd1970;

  // Leap years from year 1 through 1969
  localparam logic [YearW-1:0] EpochLeaps = 12'd477;

  // 2^15 / 25 rounded up; exact for quotients of values below 1024
  localparam logic [10:0] Recip25 = 11'd1311;

  localparam logic [ErrW-1:0] ErrOk    = 2'd0;
  localparam logic [ErrW-1:0] ErrMonth = 2'd1;
  localparam logic [ErrW-1:0] ErrYear  = 2'd2;
  localparam logic [ErrW-1:0] ErrDay   = 2'd3;

  typedef struct packed {
    logic load;
    logic calc;
    logic finish;
  } dvdc_cmd_t;

  // Days before the first of the month in a common year; 0 for bad months
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] v;
    case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Month length in a common year; 0 for bad months
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] v;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    v = 5'd30;
      4'd2:                                       v = 5'd28;
      default:                                    v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/dvdc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvdc_ctrl
// Sequencer: load, reciprocal multiply, final sum, then a one-cycle strobe.
// ----------------------------------------------------------------------------
module dvdc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output dvdc_pkg::dvdc_cmd_t cmd
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StSum  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      StIdle: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = StDiv;
        end
      end
      StDiv: begin
        cmd.calc  = 1'b1;
        state_nxt = StSum;
      end
      StSum: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = StIdle;
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != StIdle);
  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/dvdc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvdc_datapath
// Range checks, closed-form leap count and day count with saturation.
// ----------------------------------------------------------------------------
module dvdc_datapath #(
  parameter int MAX_YEAR = 2099
) (
  input  logic                   clk,
  input  dvdc_pkg::dvdc_cmd_t    cmd,
  input  logic [4:0]             in_day_of_month,
  input  logic [3:0]             in_month_number,
  input  logic [11:0]            in_year_number,
  output logic                   out_date_valid,
  output logic [1:0]             out_error_code,
  output logic [15:0]            out_day_count
);

  localparam logic [11:0] MaxYearC = 12'(MAX_YEAR);

  // Captured transaction
  logic [4:0]  day_r;
  logic [3:0]  month_r;
  logic [11:0] year_r;

  // Multiply stage
  logic [20:0] prod_n100_r;
  logic [18:0] prod_n400_r;
  logic [20:0] prod_y100_r;
  logic [18:0] prod_y400_r;
  logic [19:0] base_r;
  logic [8:0]  dbm_r;
  logic [4:0]  mlen_r;
  logic [1:0]  pre_err_r;
  logic [11:0] year_m1_r;

  // Result
  logic        valid_r;
  logic [1:0]  err_r;
  logic [15:0] count_r;

  logic [11:0] year_m1;
  logic [11:0] year_off;
  logic [1:0]  pre_err;

  logic [5:0]  q_n100;
  logic [3:0]  q_n400;
  logic [5:0]  q_y100;
  logic [3:0]  q_y400;
  logic [9:0]  rem_y100;
  logic [7:0]  rem_y400;
  logic        leap;
  logic [4:0]  len;
  logic [11:0] leaps;
  logic [20:0] sum;
  logic [1:0]  err_nxt;

  always_comb begin
    year_m1  = in_year_number - 12'd1;
    year_off = in_year_number - dvdc_pkg::EpochYear;
    if ((in_month_number < 4'd1) || (in_month_number > 4'd12)) begin
      pre_err = dvdc_pkg::ErrMonth;
    end else if ((in_year_number < dvdc_pkg::EpochYear) || (in_year_number > MaxYearC)) begin
      pre_err = dvdc_pkg::ErrYear;
    end else begin
      pre_err = dvdc_pkg::ErrOk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_r       <= in_day_of_month;
      month_r     <= in_month_number;
      year_r      <= in_year_number;
      year_m1_r   <= year_m1;
      base_r      <= 20'(year_off) * 20'd365;
      pre_err_r   <= pre_err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      prod_n100_r <= 21'(year_m1_r[11:2]) * 21'(dvdc_pkg::Recip25);
      prod_n400_r <= 19'(year_m1_r[11:4]) * 19'(dvdc_pkg::Recip25);
      prod_y100_r <= 21'(year_r[11:2]) * 21'(dvdc_pkg::Recip25);
      prod_y400_r <= 19'(year_r[11:4]) * 19'(dvdc_pkg::Recip25);
      dbm_r       <= dvdc_pkg::days_before(month_r);
      mlen_r      <= dvdc_pkg::month_len(month_r);
    end
  end

  always_comb begin
    q_n100   = prod_n100_r[20:15];
    q_n400   = prod_n400_r[18:15];
    q_y100   = prod_y100_r[20:15];
    q_y400   = prod_y400_r[18:15];
    // Remainders of year/4 by 25 and year/16 by 25
    rem_y100 = year_r[11:2] - ({4'd0, q_y100} * 10'd25);
    rem_y400 = year_r[11:4] - ({4'd0, q_y400} * 8'd25);
    leap     = (year_r[1:0] == 2'd0) &&
               ((rem_y100 != 10'd0) || ((rem_y400 == 8'd0) && (year_r[3:2] == 2'd0)));
    len      = (month_r == 4'd2 && leap) ? 5'd29 : mlen_r;
    leaps    = {2'd0, year_m1_r[11:2]} - {6'd0, q_n100} + {8'd0, q_n400}
               - dvdc_pkg::EpochLeaps;
    sum      = {1'b0, base_r} + {9'd0, leaps} + {12'd0, dbm_r} + {16'd0, day_r}
               + ((month_r > 4'd2 && leap) ? 21'd1 : 21'd0);
    if (pre_err_r != dvdc_pkg::ErrOk) begin
      err_nxt = pre_err_r;
    end else if ((day_r == 5'd0) || (day_r > len)) begin
      err_nxt = dvdc_pkg::ErrDay;
    end else begin
      err_nxt = dvdc_pkg::ErrOk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      err_r   <= err_nxt;
      valid_r <= (err_nxt == dvdc_pkg::ErrOk);
      if (err_nxt != dvdc_pkg::ErrOk) begin
        count_r <= 16'd0;
      end else if (sum > 21'd65535) begin
        count_r <= 16'hFFFF;
      end else begin
        count_r <= sum[15:0];
      end
    end
  end

  assign out_date_valid = valid_r;
  assign out_error_code = err_r;
  assign out_day_count  = count_r;

endmodule

/* hw/rtl/date_validate_to_day_count.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_validate_to_day_count
// Checks a Gregorian date and returns its day number since 1970-01-01 (day 1).
// ----------------------------------------------------------------------------
//  channel  ports                                             handshake
//  input    in_day_of_month, in_month_number, in_year_number  start & !busy
//  result   out_date_valid, out_error_code, out_day_count     out_valid strobe
//
//  A transaction steps through capture and range check, reciprocal
//  multiplies for the leap count, then the final sum; the sequencer sets the steps.
//  The result strobe comes in the cycle after the sum and overlaps the next
//  capture; a new transaction is taken only once the sequencer is back in idle.
//  Reset (rst_n low, synchronous) returns the sequencer to idle.
//  The receiver cannot stall: each out_valid strobe is high for one cycle only.
// ----------------------------------------------------------------------------
module date_validate_to_day_count #(
  parameter int MAX_YEAR = 2099
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_day_of_month,
  input  logic [3:0]  in_month_number,
  input  logic [11:0] in_year_number,
  output logic        out_valid,
  output logic        out_date_valid,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_day_count
);

  dvdc_pkg::dvdc_cmd_t cmd;

  dvdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  dvdc_datapath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .in_day_of_month (in_day_of_month),
    .in_month_number (in_month_number),
    .in_year_number  (in_year_number),
    .out_date_valid  (out_date_valid),
    .out_error_code  (out_error_code),
    .out_day_count   (out_day_count)
  );

endmodule

/* verif/tb_date_validate_to_day_count.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_date_validate_to_day_count
// Self-checking bench for the date check and day count block. Directed dates
// hit the calendar corners and every error code. Random dates follow, most
// of them close to valid. A scoreboard predicts each result and compares it
// field by field as the result strobes out.
// ----------------------------------------------------------------------------
module tb_date_validate_to_day_count;

  localparam int MaxYear       = 2099;
  localparam int RandomDates   = 1280;
  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic                        valid;
    logic [dvdc_pkg::ErrW-1:0]   err;
    logic [dvdc_pkg::CountW-1:0] count;
  } day_result_t;

  class day_count_scoreboard;
    day_result_t pending_q[$];
    int unsigned fail_count;
    int unsigned dates_checked;
    int unsigned tally[4];
    int unsigned days_ahead[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    function int unsigned leaps_through(int unsigned n);
      return n / 4 - n / 100 + n / 400;
    endfunction

    function day_result_t predict(logic [dvdc_pkg::DayW-1:0] d,
                                  logic [dvdc_pkg::MonthW-1:0] m,
                                  logic [dvdc_pkg::YearW-1:0] y);
      day_result_t res;
      int unsigned yr;
      int unsigned len;
      int unsigned total;
      bit leap;
      res = '0;
      yr = y;
      if (m < 1 || m > 12) begin
        res.err = dvdc_pkg::ErrMonth;
      end else if (yr < 1970 || yr > MaxYear) begin
        res.err = dvdc_pkg::ErrYear;
      end else begin
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        len = month_days[m - 1];
        if (m == 2 && leap) len = 29;
        if (d < 1 || d > len) begin
          res.err = dvdc_pkg::ErrDay;
        end else begin
          total = 365 * (yr - 1970) + leaps_through(yr - 1) - leaps_through(1969)
                + days_ahead[m - 1] + d;
          if (m > 2 && leap) total++;
          if (total > 65535) total = 65535;
          res.valid = 1'b1;
          res.err   = dvdc_pkg::ErrOk;
          res.count = total[dvdc_pkg::CountW-1:0];
        end
      end
      return res;
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function void note_date(logic [dvdc_pkg::DayW-1:0] d,
                            logic [dvdc_pkg::MonthW-1:0] m,
                            logic [dvdc_pkg::YearW-1:0] y);
      pending_q.push_back(predict(d, m, y));
    endfunction

    function void check_result(logic v, logic [dvdc_pkg::ErrW-1:0] e,
                               logic [dvdc_pkg::CountW-1:0] c);
      day_result_t want;
      if (pending_q.size() == 0) begin
        flag($sformatf("result valid=%0d err=%0d count=%0d with no date pending",
                       v, e, c));
        return;
      end
      want = pending_q.pop_front();
      dates_checked++;
      tally[want.err]++;
      if (v !== want.valid || e !== want.err || c !== want.count)
        flag($sformatf("exp valid=%0d err=%0d count=%0d, got valid=%0d err=%0d count=%0d",
                       want.valid, want.err, want.count, v, e, c));
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [dvdc_pkg::DayW-1:0]     in_day_of_month;
  logic [dvdc_pkg::MonthW-1:0]   in_month_number;
  logic [dvdc_pkg::YearW-1:0]    in_year_number;
  logic                          out_valid;
  logic                          out_date_valid;
  logic [dvdc_pkg::ErrW-1:0]     out_error_code;
  logic [dvdc_pkg::CountW-1:0]   out_day_count;

  day_count_scoreboard sb;
  int unsigned         idle_count;

  date_validate_to_day_count #(
    .MAX_YEAR(MaxYear)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_day_of_month(in_day_of_month),
    .in_month_number(in_month_number),
    .in_year_number (in_year_number),
    .out_valid      (out_valid),
    .out_date_valid (out_date_valid),
    .out_error_code (out_error_code),
    .out_day_count  (out_day_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hold the transaction until the block takes it
  task automatic send_date(input logic [dvdc_pkg::DayW-1:0] d,
                           input logic [dvdc_pkg::MonthW-1:0] m,
                           input logic [dvdc_pkg::YearW-1:0] y);
    start           <= 1'b1;
    in_day_of_month <= d;
    in_month_number <= m;
    in_year_number  <= y;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and scramble the fields; the block must ignore them
  task automatic hold_off(input int unsigned cycles);
    start           <= 1'b0;
    in_day_of_month <= 5'($urandom);
    in_month_number <= 4'($urandom);
    in_year_number  <= 12'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Monitor: retire results before noting the date taken on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_date_valid, out_error_code, out_day_count);
      if (start && !busy) sb.note_date(in_day_of_month, in_month_number, in_year_number);
    end
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_count = 0;
    end else begin
      idle_count++;
      if (idle_count >= WatchdogLimit) begin
        $display("Watchdog: no transaction for %0d cycles", WatchdogLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned                 pick;
    logic [dvdc_pkg::DayW-1:0]   d;
    logic [dvdc_pkg::MonthW-1:0] m;
    logic [dvdc_pkg::YearW-1:0]  y;
    bit                          quiet;

    sb = new();
    idle_count = 0;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_day_of_month <= '0;
    in_month_number <= '0;
    in_year_number  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Calendar corners and every error code
    send_date(5'd1,  4'd1,  12'd1970);
    send_date(5'd31, 4'd12, 12'(MaxYear));
    send_date(5'd29, 4'd2,  12'd1972);
    send_date(5'd29, 4'd2,  12'd1970);
    send_date(5'd29, 4'd2,  12'd2000);
    send_date(5'd28, 4'd2,  12'd2100);
    send_date(5'd0,  4'd1,  12'd1980);
    send_date(5'd31, 4'd4,  12'd1990);
    send_date(5'd30, 4'd4,  12'd1990);
    send_date(5'd31, 4'd1,  12'd1969);
    send_date(5'd1,  4'd1,  12'd0);
    send_date(5'd31, 4'd12, 12'd4095);
    send_date(5'd1,  4'd0,  12'd2000);
    send_date(5'd1,  4'd13, 12'd2000);
    send_date(5'd31, 4'd15, 12'd4095);
    send_date(5'd0,  4'd0,  12'd0);
    send_date(5'd0,  4'd6,  12'd1960);
    send_date(5'd31, 4'd3,  12'd2096);
    send_date(5'd1,  4'd3,  12'd2097);
    send_date(5'd31, 4'd11, 12'd2050);
    send_date(5'd31, 4'd7,  12'd2024);
    send_date(5'd31, 4'd8,  12'd2024);
    hold_off(3);

    for (int i = 0; i < RandomDates; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        d = 5'($urandom);
        m = 4'($urandom);
        y = 12'($urandom);
      end else begin
        y = 12'($urandom_range(1970, MaxYear));
        m = 4'($urandom_range(1, 12));
        d = ($urandom_range(0, 99) < 70) ? 5'($urandom_range(1, 28))
                                         : 5'($urandom_range(29, 31));
      end
      send_date(d, m, y);

      // Drain the pipeline once midway before resuming
      if (i == RandomDates / 2) begin
        start <= 1'b0;
        do @(posedge clk); while (sb.pending_q.size() != 0);
      end else begin
        quiet = (i >= 300 && i < 600);
        if (!quiet && $urandom_range(0, 99) < 20) hold_off($urandom_range(1, 4));
      end
    end
    start <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending_q.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.pending_q.size()));

    $display("Checked %0d dates: %0d valid, %0d bad month, %0d bad year, %0d bad day",
             sb.dates_checked, sb.tally[dvdc_pkg::ErrOk], sb.tally[dvdc_pkg::ErrMonth],
             sb.tally[dvdc_pkg::ErrYear], sb.tally[dvdc_pkg::ErrDay]);
    $display("Sender gaps, a no-gap stretch and one full drain exercised; %0d failures",
             sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
